// ===== hw/rtl/srctok_pkg.sv =====
// Shared types, token codes and keyword tables for the source tokenizer.
package srctok_pkg;

    localparam int KIND_W = 6;
    localparam int OFF_W  = 24;
    localparam int LEN_W  = 16;
    localparam int LINE_W = 20;
    localparam int CFG_W  = 20;
    localparam int NKW    = 14;

    localparam logic [KIND_W-1:0] K_LPAREN  = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN  = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE  = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE  = 6'd3;
    localparam logic [KIND_W-1:0] K_SEMI    = 6'd4;
    localparam logic [KIND_W-1:0] K_COMMA   = 6'd5;
    localparam logic [KIND_W-1:0] K_BAR     = 6'd6;
    localparam logic [KIND_W-1:0] K_OROR    = 6'd7;
    localparam logic [KIND_W-1:0] K_MINUS   = 6'd8;
    localparam logic [KIND_W-1:0] K_DEC     = 6'd9;
    localparam logic [KIND_W-1:0] K_PLUS    = 6'd10;
    localparam logic [KIND_W-1:0] K_INC     = 6'd11;
    localparam logic [KIND_W-1:0] K_SLASH   = 6'd12;
    localparam logic [KIND_W-1:0] K_STAR    = 6'd13;
    localparam logic [KIND_W-1:0] K_AMP     = 6'd14;
    localparam logic [KIND_W-1:0] K_TILDE   = 6'd15;
    localparam logic [KIND_W-1:0] K_BANG    = 6'd16;
    localparam logic [KIND_W-1:0] K_NE      = 6'd17;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd18;
    localparam logic [KIND_W-1:0] K_EQ      = 6'd19;
    localparam logic [KIND_W-1:0] K_ARROW   = 6'd20;
    localparam logic [KIND_W-1:0] K_CARET   = 6'd21;
    localparam logic [KIND_W-1:0] K_LT      = 6'd22;
    localparam logic [KIND_W-1:0] K_LE      = 6'd23;
    localparam logic [KIND_W-1:0] K_SHL     = 6'd24;
    localparam logic [KIND_W-1:0] K_GT      = 6'd25;
    localparam logic [KIND_W-1:0] K_GE      = 6'd26;
    localparam logic [KIND_W-1:0] K_SHR     = 6'd27;
    localparam logic [KIND_W-1:0] K_STRING  = 6'd28;
    localparam logic [KIND_W-1:0] K_NUMBER  = 6'd29;
    localparam logic [KIND_W-1:0] K_IDENT   = 6'd30;
    localparam logic [KIND_W-1:0] K_KW0     = 6'd31;
    localparam logic [KIND_W-1:0] K_END     = 6'd45;
    localparam logic [KIND_W-1:0] K_BADCHAR = 6'd46;
    localparam logic [KIND_W-1:0] K_OPENSTR = 6'd47;

    // characters stored lowest index first
    localparam logic [5:0][7:0] KW_TEXT [NKW] = '{
        48'("esle"), 48'("eslaf"), 48'("rof"), 48'("cnuf"), 48'("tni"),
        48'("fi"), 48'("rahc"), 48'("nruter"), 48'("tel"), 48'("rav"),
        48'("diov"), 48'("labolg"), 48'("gnirts"), 48'("elihw")};
    localparam logic [2:0] KW_LEN [NKW] = '{
        3'd4, 3'd5, 3'd3, 3'd4, 3'd3, 3'd2, 3'd4,
        3'd6, 3'd3, 3'd3, 3'd4, 3'd6, 3'd6, 3'd5};

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_SLASH   = 9'b000000010,
        M_COMMENT = 9'b000000100,
        M_OP      = 9'b000001000,
        M_IDENT   = 9'b000010000,
        M_INT     = 9'b000100000,
        M_DOT     = 9'b001000000,
        M_FRAC    = 9'b010000000,
        M_STR     = 9'b100000000
    } scan_mode_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } pair_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
    } result_t;

    typedef struct packed {
        logic [1:0]       count;
        result_t [2:0]    res;
    } group_t;

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] h);
        logic [KIND_W-1:0] k;
        case (h)
            "|":     k = K_BAR;
            "-":     k = K_MINUS;
            "+":     k = K_PLUS;
            "!":     k = K_BANG;
            "=":     k = K_ASSIGN;
            "<":     k = K_LT;
            default: k = K_GT;
        endcase
        return k;
    endfunction

    function automatic pair_t pair_kind(input logic [7:0] h, input logic [7:0] c);
        pair_t p;
        p.hit  = 1'b1;
        p.kind = K_OROR;
        if (h == "|" && c == "|") p.kind = K_OROR;
        else if (h == "-" && c == "-") p.kind = K_DEC;
        else if (h == "+" && c == "+") p.kind = K_INC;
        else if (h == "!" && c == "=") p.kind = K_NE;
        else if (h == "=" && c == "=") p.kind = K_EQ;
        else if (h == "=" && c == ">") p.kind = K_ARROW;
        else if (h == "<" && c == "=") p.kind = K_LE;
        else if (h == "<" && c == "<") p.kind = K_SHL;
        else if (h == ">" && c == "=") p.kind = K_GE;
        else if (h == ">" && c == ">") p.kind = K_SHR;
        else p.hit = 1'b0;
        return p;
    endfunction

    function automatic logic [KIND_W-1:0] kw_lookup(input logic [5:0][7:0] prefix,
                                                    input logic [2:0] len);
        logic [KIND_W-1:0] k;
        logic              eq;
        k = K_IDENT;
        for (int kk = 0; kk < NKW; kk++) begin
            eq = (len == KW_LEN[kk]);
            for (int i = 0; i < 6; i++) begin
                if (3'(i) < KW_LEN[kk] && prefix[i] != KW_TEXT[kk][i]) eq = 1'b0;
            end
            if (eq) k = K_KW0 + KIND_W'(kk);
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/srctok_scanner.sv =====
// Scanner state and combinational token decision for one source byte.
module srctok_scanner #(
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [7:0]                       in_byte,
    input  logic                             in_end,
    input  logic                             cfg_we,
    input  logic [srctok_pkg::CFG_W-1:0]     cfg_value,
    output srctok_pkg::group_t               grp
);

    localparam int CW = (LINE_BITS > srctok_pkg::CFG_W) ? LINE_BITS : srctok_pkg::CFG_W;

    srctok_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [5:0][7:0]        pref_reg, pref_next;
    logic [OFFSET_BITS-1:0] tb_reg, tb_next, off_reg, off_next;
    logic [LENGTH_BITS-1:0] tl_reg, tl_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   fin_reg, fin_next;

    logic [7:0]             c;
    logic                   is_al, is_dg;
    logic [LENGTH_BITS-1:0] tl_inc, tl_inc2;
    logic [OFFSET_BITS-1:0] off_inc, dot_off;
    logic [LINE_BITS-1:0]   line_inc;
    logic [CW-1:0]          cfg_ext, lmax_ext;

    logic                          p_v, d_v;
    logic [srctok_pkg::KIND_W-1:0] p_kind;

    srctok_pkg::scan_mode_t        s_mode;
    logic                          s_tv, s_held, s_ident, s_nl;
    logic [srctok_pkg::KIND_W-1:0] s_kind;

    logic                          do_flush, do_start, t_v;
    logic [srctok_pkg::KIND_W-1:0] t_kind;
    logic [OFFSET_BITS-1:0]        t_start;
    logic [LENGTH_BITS-1:0]        t_len;
    srctok_pkg::pair_t             pr;

    srctok_pkg::result_t r_p, r_d, r_t;

    assign c        = in_byte;
    assign is_al    = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
    assign is_dg    = (c >= "0") && (c <= "9");
    assign tl_inc   = (tl_reg == '1) ? tl_reg : tl_reg + 1'b1;
    assign tl_inc2  = (tl_inc == '1) ? tl_inc : tl_inc + 1'b1;
    assign off_inc  = (off_reg == '1) ? off_reg : off_reg + 1'b1;
    assign dot_off  = (off_reg == '0) ? off_reg : off_reg - 1'b1;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign cfg_ext  = CW'(cfg_value);
    assign lmax_ext = CW'({LINE_BITS{1'b1}});
    assign pr       = srctok_pkg::pair_kind(held_reg, c);

    // pending token flush
    always_comb begin
        p_v    = 1'b0;
        d_v    = 1'b0;
        p_kind = srctok_pkg::K_NUMBER;
        case (mode_reg)
            srctok_pkg::M_SLASH: begin
                p_v    = 1'b1;
                p_kind = srctok_pkg::K_SLASH;
            end
            srctok_pkg::M_OP: begin
                p_v    = 1'b1;
                p_kind = srctok_pkg::single_kind(held_reg);
            end
            srctok_pkg::M_IDENT: begin
                p_v    = 1'b1;
                p_kind = (tl_reg > LENGTH_BITS'(6)) ? srctok_pkg::K_IDENT :
                         srctok_pkg::kw_lookup(pref_reg, tl_reg[2:0]);
            end
            srctok_pkg::M_INT, srctok_pkg::M_FRAC: begin
                p_v = 1'b1;
            end
            srctok_pkg::M_DOT: begin
                p_v = 1'b1;
                d_v = 1'b1;
            end
            srctok_pkg::M_STR: begin
                p_v    = in_end;
                p_kind = srctok_pkg::K_OPENSTR;
            end
            default: ;
        endcase
    end

    // byte seen between tokens
    always_comb begin
        s_mode  = srctok_pkg::M_IDLE;
        s_tv    = 1'b0;
        s_kind  = srctok_pkg::K_BADCHAR;
        s_held  = 1'b0;
        s_ident = 1'b0;
        s_nl    = 1'b0;
        case (c)
            8'h20, 8'h0D, 8'h09: ;
            8'h0A: s_nl = 1'b1;
            "/":   s_mode = srctok_pkg::M_SLASH;
            8'h22: s_mode = srctok_pkg::M_STR;
            "|", "-", "+", "!", "=", "<", ">": begin
                s_mode = srctok_pkg::M_OP;
                s_held = 1'b1;
            end
            "(": begin s_tv = 1'b1; s_kind = srctok_pkg::K_LPAREN; end
            ")": begin s_tv = 1'b1; s_kind = srctok_pkg::K_RPAREN; end
            "{": begin s_tv = 1'b1; s_kind = srctok_pkg::K_LBRACE; end
            "}": begin s_tv = 1'b1; s_kind = srctok_pkg::K_RBRACE; end
            ";": begin s_tv = 1'b1; s_kind = srctok_pkg::K_SEMI; end
            ",": begin s_tv = 1'b1; s_kind = srctok_pkg::K_COMMA; end
            "*": begin s_tv = 1'b1; s_kind = srctok_pkg::K_STAR; end
            "&": begin s_tv = 1'b1; s_kind = srctok_pkg::K_AMP; end
            "~": begin s_tv = 1'b1; s_kind = srctok_pkg::K_TILDE; end
            "^": begin s_tv = 1'b1; s_kind = srctok_pkg::K_CARET; end
            default: begin
                if (is_al) begin
                    s_mode  = srctok_pkg::M_IDENT;
                    s_ident = 1'b1;
                end else if (is_dg) begin
                    s_mode = srctok_pkg::M_INT;
                end else begin
                    s_tv = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        pref_next = pref_reg;
        tb_next   = tb_reg;
        tl_next   = tl_reg;
        off_next  = off_reg;
        line_next = line_reg;
        fin_next  = fin_reg;
        do_flush  = 1'b0;
        do_start  = 1'b0;
        t_v       = 1'b0;
        t_kind    = srctok_pkg::K_END;
        t_start   = tb_reg;
        t_len     = tl_reg;
        if (cfg_we) begin
            line_next = (cfg_ext > lmax_ext) ? LINE_BITS'(lmax_ext) : LINE_BITS'(cfg_ext);
        end
        if (accept && !fin_reg) begin
            if (in_end) begin
                do_flush  = 1'b1;
                t_v       = 1'b1;
                t_kind    = srctok_pkg::K_END;
                t_start   = off_reg;
                t_len     = '0;
                fin_next  = 1'b1;
                mode_next = srctok_pkg::M_IDLE;
            end else begin
                off_next = off_inc;
                case (mode_reg)
                    srctok_pkg::M_SLASH: begin
                        if (c == "/") mode_next = srctok_pkg::M_COMMENT;
                        else do_start = 1'b1;
                    end
                    srctok_pkg::M_COMMENT: begin
                        if (c == 8'h0A) begin
                            line_next = line_inc;
                            mode_next = srctok_pkg::M_IDLE;
                        end
                    end
                    srctok_pkg::M_OP: begin
                        if (pr.hit) begin
                            t_v       = 1'b1;
                            t_kind    = pr.kind;
                            t_len     = LENGTH_BITS'(2);
                            mode_next = srctok_pkg::M_IDLE;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    srctok_pkg::M_IDENT: begin
                        if (is_al || is_dg) begin
                            for (int i = 0; i < 6; i++) begin
                                if (tl_reg == LENGTH_BITS'(i)) pref_next[i] = c;
                            end
                            tl_next = tl_inc;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    srctok_pkg::M_INT: begin
                        if (is_dg) tl_next = tl_inc;
                        else if (c == ".") mode_next = srctok_pkg::M_DOT;
                        else do_start = 1'b1;
                    end
                    srctok_pkg::M_DOT: begin
                        if (is_dg) begin
                            tl_next   = tl_inc2;
                            mode_next = srctok_pkg::M_FRAC;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    srctok_pkg::M_FRAC: begin
                        if (is_dg) tl_next = tl_inc;
                        else do_start = 1'b1;
                    end
                    srctok_pkg::M_STR: begin
                        tl_next = tl_inc;
                        if (c == 8'h0A) begin
                            line_next = line_inc;
                        end else if (c == 8'h22) begin
                            t_v       = 1'b1;
                            t_kind    = srctok_pkg::K_STRING;
                            t_len     = tl_inc;
                            mode_next = srctok_pkg::M_IDLE;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
                if (do_start) begin
                    do_flush  = (mode_reg != srctok_pkg::M_IDLE);
                    tb_next   = off_reg;
                    tl_next   = LENGTH_BITS'(1);
                    mode_next = s_mode;
                    t_v       = s_tv;
                    t_kind    = s_kind;
                    t_start   = off_reg;
                    t_len     = LENGTH_BITS'(1);
                    if (s_held) held_next = c;
                    if (s_ident) pref_next[0] = c;
                    if (s_nl) line_next = line_inc;
                end
            end
        end
    end

    always_comb begin
        r_p.kind  = p_kind;
        r_p.start = srctok_pkg::OFF_W'(tb_reg);
        r_p.len   = srctok_pkg::LEN_W'(tl_reg);
        r_p.line  = srctok_pkg::LINE_W'(line_reg);
        r_d.kind  = srctok_pkg::K_BADCHAR;
        r_d.start = srctok_pkg::OFF_W'(dot_off);
        r_d.len   = srctok_pkg::LEN_W'(1);
        r_d.line  = srctok_pkg::LINE_W'(line_reg);
        r_t.kind  = t_kind;
        r_t.start = srctok_pkg::OFF_W'(t_start);
        r_t.len   = srctok_pkg::LEN_W'(t_len);
        r_t.line  = srctok_pkg::LINE_W'(line_reg);
        grp.res[0] = (do_flush && p_v) ? r_p : r_t;
        grp.res[1] = (do_flush && d_v) ? r_d : r_t;
        grp.res[2] = r_t;
        grp.count  = 2'(do_flush && p_v) + 2'(do_flush && d_v) + 2'(t_v);
    end

    always_ff @(posedge aclk) begin
        pref_reg <= pref_next;
        if (!aresetn) begin
            mode_reg <= srctok_pkg::M_IDLE;
            off_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            fin_reg  <= 1'b0;
            held_reg <= '0;
            tb_reg   <= '0;
            tl_reg   <= '0;
        end else begin
            mode_reg <= mode_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            fin_reg  <= fin_next;
            held_reg <= held_next;
            tb_reg   <= tb_next;
            tl_reg   <= tl_next;
        end
    end

endmodule

// ===== hw/rtl/srctok_outbuf.sv =====
// Result register holding the tokens of one byte and sending them as beats.
module srctok_outbuf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  srctok_pkg::group_t              grp_in,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tuser,  // token_kind[5:0], zero
    output logic [63:0]                     m_tdata,  // start_offset, token_length, line_number
    output logic                            m_tlast
);

    srctok_pkg::group_t  grp_reg;
    logic [1:0]          cnt_reg, idx_reg;
    logic                last_beat, fire;
    srctok_pkg::result_t cur;

    assign cur       = grp_reg.res[idx_reg];
    assign last_beat = (idx_reg == cnt_reg - 2'd1);
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign fire      = m_tvalid && m_tready;
    assign in_ready  = !m_tvalid || (fire && last_beat);
    assign m_tlast   = last_beat;
    assign m_tuser   = {2'b00, cur.kind};
    assign m_tdata   = {4'h0, cur.line, cur.len, cur.start};

    always_ff @(posedge aclk) begin
        if (load) grp_reg <= grp_in;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= grp_in.count;
            idx_reg <= 2'd0;
        end else if (fire) begin
            if (last_beat) cnt_reg <= 2'd0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== hw/rtl/source_tokenizer.sv =====
// Top level of the source tokenizer: byte stream in, token stream out.
// A token is registered in the output buffer when the byte that completes it is taken.
// Throughput: one byte per cycle while each byte yields at most one token and m_tready
// is high; a byte yielding two or three tokens stalls the input until its last beat is taken.
// Reset: aresetn low, synchronous; scanner idle, offsets zero, line count 1,
// output empty.
module source_tokenizer #(
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // source_byte[7:0]
    input  logic [7:0]  s_tuser,   // end_of_source[0], unused
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // start_offset[23:0], token_length[39:24], line_number[59:40]
    output logic [7:0]  m_tuser,   // token_kind[5:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    srctok_pkg::group_t grp;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    srctok_scanner #(
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS),
        .LINE_BITS(LINE_BITS)
    ) u_scanner (
        .aclk(aclk),
        .aresetn(aresetn),
        .accept(accept),
        .in_byte(s_tdata),
        .in_end(s_tuser[0]),
        .cfg_we(cfg_valid && cfg_ready),
        .cfg_value(cfg_data),
        .grp(grp)
    );

    srctok_outbuf u_outbuf (
        .aclk(aclk),
        .aresetn(aresetn),
        .load(accept),
        .grp_in(grp),
        .in_ready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

endmodule

// ===== dv/tb_source_tokenizer.sv =====
// Self-checking testbench for source_tokenizer: byte stream in, token beats checked.
module tb_source_tokenizer;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [srctok_pkg::KIND_W-1:0] kind;
        logic [srctok_pkg::OFF_W-1:0]  start;
        logic [srctok_pkg::LEN_W-1:0]  len;
        logic [srctok_pkg::LINE_W-1:0] line;
        logic                          last;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [7:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data = '0;

    source_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial forever #5 aclk = ~aclk;

    // scanner copy
    srctok_pkg::scan_mode_t        mode = srctok_pkg::M_IDLE;
    logic [7:0]                    held = '0;
    logic [7:0]                    kw_prefix [6];
    logic [srctok_pkg::OFF_W-1:0]  tok_begin = '0;
    logic [srctok_pkg::LEN_W-1:0]  tok_len = '0;
    logic [srctok_pkg::OFF_W-1:0]  offset = '0;
    logic [srctok_pkg::LINE_W-1:0] line_cnt = 20'd1;
    logic                          done = 1'b0;

    token_t item_tokens[$];
    token_t expected_tokens[$];

    int idle_s = 0;
    int idle_r = 0;
    int fails = 0;
    int n_tokens = 0;
    int n_bytes = 0;
    int cycles = 0;

    string kw_names [srctok_pkg::NKW] = '{"else", "false", "for", "func", "int", "if", "char",
                              "return", "let", "var", "void", "global", "string", "while"};
    string op_texts [17] = '{"|", "||", "-", "--", "+", "++", "!", "!=", "=", "==", "=>",
                             "<", "<=", "<<", ">", ">=", ">>"};
    string punct = "(){};,*&~^/";
    logic [7:0] blank_chars [4] = '{8'h20, 8'h0A, 8'h09, 8'h0D};

    function automatic bit is_letter(logic [7:0] c);
        return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(logic [srctok_pkg::KIND_W-1:0] k,
                                 logic [srctok_pkg::OFF_W-1:0] s,
                                 logic [srctok_pkg::LEN_W-1:0] l);
        token_t t;
        t.kind = k; t.start = s; t.len = l; t.line = line_cnt; t.last = 1'b0;
        item_tokens.push_back(t);
    endfunction

    function automatic void bump_len();
        if (tok_len != '1) tok_len++;
    endfunction

    function automatic void bump_line();
        if (line_cnt != '1) line_cnt++;
    endfunction

    function automatic logic [srctok_pkg::KIND_W-1:0] word_kind();
        string w;
        w = "";
        if (tok_len > 6) return srctok_pkg::K_IDENT;
        for (int i = 0; i < tok_len; i++) w = {w, string'(kw_prefix[i])};
        for (int k = 0; k < srctok_pkg::NKW; k++)
            if (w == kw_names[k]) return srctok_pkg::K_KW0 + srctok_pkg::KIND_W'(k);
        return srctok_pkg::K_IDENT;
    endfunction

    function automatic logic [srctok_pkg::KIND_W-1:0] lone_op(logic [7:0] h);
        case (h)
            "|": return srctok_pkg::K_BAR;
            "-": return srctok_pkg::K_MINUS;
            "+": return srctok_pkg::K_PLUS;
            "!": return srctok_pkg::K_BANG;
            "=": return srctok_pkg::K_ASSIGN;
            "<": return srctok_pkg::K_LT;
            default: return srctok_pkg::K_GT;
        endcase
    endfunction

    // returns K_END when the pair is no operator
    function automatic logic [srctok_pkg::KIND_W-1:0] paired_op(logic [7:0] h, logic [7:0] c);
        case ({h, c})
            {"|", "|"}: return srctok_pkg::K_OROR;
            {"-", "-"}: return srctok_pkg::K_DEC;
            {"+", "+"}: return srctok_pkg::K_INC;
            {"!", "="}: return srctok_pkg::K_NE;
            {"=", "="}: return srctok_pkg::K_EQ;
            {"=", ">"}: return srctok_pkg::K_ARROW;
            {"<", "="}: return srctok_pkg::K_LE;
            {"<", "<"}: return srctok_pkg::K_SHL;
            {">", "="}: return srctok_pkg::K_GE;
            {">", ">"}: return srctok_pkg::K_SHR;
            default: return srctok_pkg::K_END;
        endcase
    endfunction

    function automatic void begin_token(logic [7:0] c);
        logic [srctok_pkg::KIND_W-1:0] k;
        mode = srctok_pkg::M_IDLE;
        tok_begin = offset;
        tok_len = srctok_pkg::LEN_W'(1);
        k = srctok_pkg::K_END;
        case (c)
            8'h20, 8'h0D, 8'h09: return;
            8'h0A: begin bump_line(); return; end
            "/": begin mode = srctok_pkg::M_SLASH; return; end
            8'h22: begin mode = srctok_pkg::M_STR; return; end
            "|", "-", "+", "!", "=", "<", ">": begin
                held = c;
                mode = srctok_pkg::M_OP;
                return;
            end
            "(": k = srctok_pkg::K_LPAREN;
            ")": k = srctok_pkg::K_RPAREN;
            "{": k = srctok_pkg::K_LBRACE;
            "}": k = srctok_pkg::K_RBRACE;
            ";": k = srctok_pkg::K_SEMI;
            ",": k = srctok_pkg::K_COMMA;
            "*": k = srctok_pkg::K_STAR;
            "&": k = srctok_pkg::K_AMP;
            "~": k = srctok_pkg::K_TILDE;
            "^": k = srctok_pkg::K_CARET;
            default: ;
        endcase
        if (k != srctok_pkg::K_END) emit(k, tok_begin, srctok_pkg::LEN_W'(1));
        else if (is_letter(c)) begin kw_prefix[0] = c; mode = srctok_pkg::M_IDENT; end
        else if (is_num(c)) mode = srctok_pkg::M_INT;
        else emit(srctok_pkg::K_BADCHAR, tok_begin, srctok_pkg::LEN_W'(1));
    endfunction

    function automatic void flush_token(bit at_end);
        case (mode)
            srctok_pkg::M_SLASH: emit(srctok_pkg::K_SLASH, tok_begin, srctok_pkg::LEN_W'(1));
            srctok_pkg::M_OP: emit(lone_op(held), tok_begin, srctok_pkg::LEN_W'(1));
            srctok_pkg::M_IDENT: emit(word_kind(), tok_begin, tok_len);
            srctok_pkg::M_INT, srctok_pkg::M_FRAC: emit(srctok_pkg::K_NUMBER, tok_begin, tok_len);
            srctok_pkg::M_DOT: begin
                emit(srctok_pkg::K_NUMBER, tok_begin, tok_len);
                emit(srctok_pkg::K_BADCHAR, (offset != '0) ? offset - 1'b1 : '0,
                     srctok_pkg::LEN_W'(1));
            end
            srctok_pkg::M_STR: if (at_end) emit(srctok_pkg::K_OPENSTR, tok_begin, tok_len);
            default: ;
        endcase
        mode = srctok_pkg::M_IDLE;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, bit eos);
        logic [srctok_pkg::KIND_W-1:0] k;
        if (done) return;
        item_tokens.delete();
        if (eos) begin
            flush_token(1'b1);
            emit(srctok_pkg::K_END, offset, '0);
            done = 1'b1;
        end else begin
            case (mode)
                srctok_pkg::M_SLASH: if (c == "/") mode = srctok_pkg::M_COMMENT;
                         else begin flush_token(1'b0); begin_token(c); end
                srctok_pkg::M_COMMENT: if (c == 8'h0A) begin
                    bump_line();
                    mode = srctok_pkg::M_IDLE;
                end
                srctok_pkg::M_OP: begin
                    k = paired_op(held, c);
                    if (k != srctok_pkg::K_END) begin
                        emit(k, tok_begin, srctok_pkg::LEN_W'(2));
                        mode = srctok_pkg::M_IDLE;
                    end else begin flush_token(1'b0); begin_token(c); end
                end
                srctok_pkg::M_IDENT: if (is_letter(c) || is_num(c)) begin
                    if (tok_len < 6) kw_prefix[tok_len] = c;
                    bump_len();
                end else begin flush_token(1'b0); begin_token(c); end
                srctok_pkg::M_INT: if (is_num(c)) bump_len();
                       else if (c == ".") mode = srctok_pkg::M_DOT;
                       else begin flush_token(1'b0); begin_token(c); end
                srctok_pkg::M_DOT: if (is_num(c)) begin
                    bump_len();
                    bump_len();
                    mode = srctok_pkg::M_FRAC;
                end else begin flush_token(1'b0); begin_token(c); end
                srctok_pkg::M_FRAC: if (is_num(c)) bump_len();
                        else begin flush_token(1'b0); begin_token(c); end
                srctok_pkg::M_STR: begin
                    bump_len();
                    if (c == 8'h0A) bump_line();
                    else if (c == 8'h22) begin
                        emit(srctok_pkg::K_STRING, tok_begin, tok_len);
                        mode = srctok_pkg::M_IDLE;
                    end
                end
                default: begin_token(c);
            endcase
            if (offset != '1) offset++;
        end
        if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last = 1'b1;
        foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (token %0d)", what, got, want, n_tokens);
        fails++;
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= idle_r);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report("unexpected beat, kind", m_tuser[5:0], -1);
            end else begin
                token_t t;
                t = expected_tokens.pop_front();
                if (m_tuser[5:0] != t.kind) report("kind", m_tuser[5:0], t.kind);
                if (m_tdata[23:0] != t.start) report("start", m_tdata[23:0], t.start);
                if (m_tdata[39:24] != t.len) report("length", m_tdata[39:24], t.len);
                if (m_tdata[59:40] != t.line) report("line", m_tdata[59:40], t.line);
                if (m_tlast != t.last) report("last", m_tlast, t.last);
            end
            n_tokens++;
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_beat(logic [7:0] c, bit eos);
        if ($urandom_range(0, 99) < idle_s) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < idle_s);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= {7'd0, eos};
        do @(posedge aclk); while (!s_tready);
        predict_tokens(c, eos);
        n_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_first_line(logic [19:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        line_cnt = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_text("if(){};,*&~^/x\n");
        send_text("12.x 3.25");
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_text(".\"a\n\"//c\n");
    endtask

    task automatic send_fragment();
        int n;
        case ($urandom_range(0, 9))
            0: send_text({kw_names[$urandom_range(0, srctok_pkg::NKW - 1)], " "});
            1: begin
                n = $urandom_range(1, 8);
                send_beat($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                               : 8'("A" + $urandom_range(0, 25)), 1'b0);
                repeat (n - 1)
                    send_beat($urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9))
                                                        : 8'("a" + $urandom_range(0, 25)), 1'b0);
            end
            2: begin
                repeat ($urandom_range(1, 4)) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_beat(".", 1'b0);
                    repeat ($urandom_range(0, 3))
                        send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            end
            3: send_text("7.");
            4: begin
                send_beat(8'h22, 1'b0);
                repeat ($urandom_range(0, 5))
                    send_beat($urandom_range(0, 5) == 0 ? 8'h0A : 8'($urandom_range(32, 126)),
                              1'b0);
                send_beat(8'h22, 1'b0);
            end
            5: send_text(op_texts[$urandom_range(0, 16)]);
            6: begin
                send_text("//");
                repeat ($urandom_range(0, 4)) send_beat(8'($urandom_range(32, 255)), 1'b0);
                send_beat(8'h0A, 1'b0);
            end
            7: send_beat(blank_chars[$urandom_range(0, 3)], 1'b0);
            8: send_beat(8'($urandom_range(0, 255)), 1'b0);
            default: send_beat(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
        endcase
    endtask

    task automatic test_random(int count, int si, int ri);
        int base;
        idle_s = si;
        idle_r = ri;
        base = n_bytes;
        while (n_bytes - base < count) send_fragment();
    endtask

    task automatic test_long_word();
        send_text("returns ");
        send_text("whil ");
        send_text("lengthyname9x ");
    endtask

    task automatic test_end_of_source();
        send_text("\"ab");
        send_beat(8'h41, 1'b1);
        repeat (3) send_beat(8'($urandom_range(0, 255)), 1'b0);
        drain();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_first_line(20'd0);
        test_directed();
        set_first_line(20'hffffe);
        test_random(75, 13, 86);
        set_first_line(20'($urandom_range(2, 1000000)));
        test_random(75, 86, 13);
        set_first_line(20'd1);
        test_random(75, 0, 0);
        test_long_word();
        test_end_of_source();
        $display("covered %0d source bytes and %0d token beats over four line settings",
                 n_bytes, n_tokens);
        $display("including line saturation, long non-keyword words and an open string at end");
        if (fails == 0 && expected_tokens.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d tokens never seen", fails, expected_tokens.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== source_tokenizer.f =====
hw/rtl/srctok_pkg.sv
hw/rtl/srctok_scanner.sv
hw/rtl/srctok_outbuf.sv
hw/rtl/source_tokenizer.sv
dv/tb_source_tokenizer.sv
